/* rtl/life_automaton_generation_core_defines.svh */
// Assertion macros for the life automaton generation core.
// Included by the top level; no other dependencies.
`ifndef LIFE_AUTOMATON_GENERATION_CORE_DEFINES_SVH
`define LIFE_AUTOMATON_GENERATION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lag: implication check failed");
`define LAG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lag: next-cycle check failed");
`else
`define LAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LAG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lag_pkg.sv */
// Shared types, constants and functions of the life automaton generation core.
// No dependencies.
`default_nettype none
package lag_pkg;

    localparam int DEF_MAX_ROWS = 128;
    localparam int DEF_MAX_COLS = 128;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    localparam logic [7:0] RST_DIM = 8'd100;

    localparam logic CFG_ROWS_IDX = 1'b0;
    localparam logic CFG_COLS_IDX = 1'b1;

    localparam logic ACT_CELL  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic mid;
        logic up;
    } t_cell_bits;

    typedef struct packed {
        logic shift;
        logic load;
    } t_ring_ctl;

    typedef struct packed {
        logic next_cell;
        logic last_of_frame;
    } t_result;

    function automatic logic life_rule(input logic [8:0] w);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                n = n + {3'b000, w[i]};
            end
        end
        if (w[4]) begin
            life_rule = (n == 4'd2) || (n == 4'd3);
        end else begin
            life_rule = (n == 4'd3);
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/lag_cell.sv */
// One column cell of the line-store ring: holds the two rows above the input row.
// Depends on lag_pkg.
`default_nettype none
module lag_cell #(
    parameter int IDX = 0,
    parameter int CW  = $clog2(lag_pkg::DEF_MAX_COLS + 1)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  lag_pkg::t_ring_ctl      i_ctl,
    input  wire [CW-1:0]            i_tail_idx,
    input  lag_pkg::t_cell_bits     i_next,
    input  lag_pkg::t_cell_bits     i_wrap,
    output lag_pkg::t_cell_bits     o_state
);
    import lag_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    t_cell_bits r_state;
    t_cell_bits n_state;

    always_comb begin
        n_state = r_state;
        if (i_ctl.shift) begin
            if (MY_IDX == i_tail_idx) begin
                n_state = i_wrap;
            end else if (MY_IDX < i_tail_idx) begin
                n_state = i_next;
            end
        end else if (i_ctl.load && (IDX == 0)) begin
            n_state = i_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

/* rtl/lag_out_buf.sv */
// Output register with skid stage for result items.
// Depends on lag_pkg.
`default_nettype none
module lag_out_buf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  lag_pkg::t_result    i_data,
    output logic                o_full,
    output logic                o_valid,
    output lag_pkg::t_result    o_data,
    input  wire                 i_stall
);
    import lag_pkg::*;

    logic    r_ov;
    logic    r_sv;
    t_result r_od;
    t_result r_sd;
    logic    take;

    assign take = r_ov && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_sv <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_ov || take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) begin
                r_od <= r_sd;
            end
        end else if (i_push) begin
            if (!r_ov || take) begin
                r_od <= i_data;
            end else begin
                r_sd <= i_data;
            end
        end
    end

    assign o_full  = r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule
`default_nettype wire

/* rtl/life_automaton_generation_core.sv */
// Top level of the life automaton generation core: position tracking, 3x3 window, rule.
// Depends on lag_pkg, lag_cell, lag_out_buf and the assertion macro header.
//
// Computes one B3/S23 generation over a rows_in_use x cols_in_use grid streamed in
// raster order, one cell item per clock unless stalled, results one row and one
// column behind, last cell marked; cols_in_use+1 flush items drain a frame. The two
// line stores are a ring of column cells that rotates one step per item, so an item
// is taken every cycle while the output skid stage has room. After a configuration
// write the ring realigns to the new row length, one step per cycle, while the input
// stalls; the input also stalls after reset while the ring takes its length. Reset
// sets both dimensions to RST_DIM and clears position, window, ring and valid flags.
`default_nettype none
`include "life_automaton_generation_core_defines.svh"
module life_automaton_generation_core #(
    parameter int MAX_ROWS = lag_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lag_pkg::DEF_MAX_COLS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_action,
    input  wire                          i_cell_value,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_next_cell,
    output logic                         o_last_of_frame,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [lag_pkg::ADDR_W-1:0]    paddr,
    input  wire [lag_pkg::DATA_W-1:0]    pwdata,
    output logic [lag_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import lag_pkg::*;

    localparam int IW  = $clog2(MAX_COLS);
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int RW  = $clog2(MAX_ROWS + 2);
    localparam int EWC = (CW > 8) ? CW : 8;
    localparam int EWR = (RW > 8) ? RW : 8;

    logic [7:0]    r_rows;
    logic [7:0]    r_cols;
    logic [RW-1:0] r_in_row;
    logic [IW-1:0] r_in_col;
    logic [8:0]    r_window;
    logic [IW-1:0] r_phase;
    logic [CW-1:0] r_len;

    logic [RW-1:0] n_in_row;
    logic [IW-1:0] n_in_col;
    logic [IW-1:0] n_phase;

    logic [EWR-1:0] rows_ext;
    logic [EWC-1:0] cols_ext;
    logic [RW-1:0]  reff;
    logic [RW-1:0]  reff_p1;
    logic [CW-1:0]  ceff;
    logic           restart_need;
    logic           realign;
    logic           rot;
    logic           buf_full;
    logic           in_acc;

    logic           v;
    logic [2:0]     colvec;
    logic [8:0]     win_new;
    logic [8:0]     w;
    logic           res_valid;
    logic           at_left;
    logic           at_right;
    logic           at_top;
    logic           at_bot;
    logic           res_last;
    logic [CW-1:0]  col_p1;
    t_result        res;
    t_result        out_data;

    t_ring_ctl      ring_ctl;
    t_cell_bits     wrap_bits;
    t_cell_bits     cell_q [MAX_COLS];

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RST_DIM;
            r_cols <= RST_DIM;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == CFG_ROWS_IDX) begin
                r_rows <= pwdata[7:0];
            end else begin
                r_cols <= pwdata[7:0];
            end
        end
    end

    assign prdata = {24'd0, (paddr[2] == CFG_COLS_IDX) ? r_cols : r_rows};
    assign pready = 1'b1;

    // effective dimensions
    always_comb begin
        rows_ext = EWR'(r_rows);
        cols_ext = EWC'(r_cols);
        if (r_rows == 8'd0) begin
            reff = RW'(1);
        end else if (rows_ext > EWR'(MAX_ROWS)) begin
            reff = RW'(MAX_ROWS);
        end else begin
            reff = RW'(rows_ext);
        end
        if (r_cols == 8'd0) begin
            ceff = CW'(1);
        end else if (cols_ext > EWC'(MAX_COLS)) begin
            ceff = CW'(MAX_COLS);
        end else begin
            ceff = CW'(cols_ext);
        end
        reff_p1 = RW'(reff + RW'(1));
    end

    assign restart_need = (r_in_row > reff_p1) || (CW'(r_in_col) >= ceff);
    assign realign      = (r_len != ceff) || (r_phase != r_in_col);
    assign o_stall      = buf_full || restart_need || realign;
    assign in_acc       = i_valid && !o_stall;
    assign rot          = !in_acc && (((r_len != ceff) && (r_phase != '0))
                        || ((r_len == ceff) && (r_phase != r_in_col)));

    // window and rule
    always_comb begin
        v       = (i_action == ACT_CELL) && (r_in_row < reff) && i_cell_value;
        colvec  = {v, cell_q[0].mid, cell_q[0].up};
        win_new = {colvec, r_window[8:3]};
        if (r_in_col == '0) begin
            w         = {3'b000, r_window[8:3]};
            res_valid = (r_in_row >= RW'(2)) && (RW'(r_in_row - RW'(2)) < reff);
            at_left   = (ceff == CW'(1));
            at_right  = 1'b1;
            at_top    = (r_in_row == RW'(2));
            at_bot    = (r_in_row == reff_p1);
        end else begin
            w         = win_new;
            res_valid = (r_in_row >= RW'(1)) && (RW'(r_in_row - RW'(1)) < reff);
            at_left   = (r_in_col == IW'(1));
            at_right  = 1'b0;
            at_top    = (r_in_row == RW'(1));
            at_bot    = (r_in_row == reff);
        end
        if (at_left) begin
            w = w & 9'h1F8;
        end
        if (at_right) begin
            w = w & 9'h03F;
        end
        if (at_top) begin
            w = w & 9'h1B6;
        end
        if (at_bot) begin
            w = w & 9'h0DB;
        end
        res_last          = res_valid && at_bot && at_right;
        res.next_cell     = life_rule(w);
        res.last_of_frame = res_last;
    end

    // next raster position
    always_comb begin
        col_p1 = CW'(r_in_col) + CW'(1);
        if (res_last) begin
            n_in_row = '0;
            n_in_col = '0;
        end else if (col_p1 >= ceff) begin
            n_in_row = RW'(r_in_row + RW'(1));
            n_in_col = '0;
        end else begin
            n_in_row = r_in_row;
            n_in_col = IW'(col_p1);
        end
        if (CW'(r_phase) + CW'(1) == r_len) begin
            n_phase = '0;
        end else begin
            n_phase = IW'(CW'(r_phase) + CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= '0;
            r_in_col <= '0;
            r_window <= '0;
            r_phase  <= '0;
            r_len    <= CW'(1);
        end else begin
            if (in_acc) begin
                r_in_row <= n_in_row;
                r_in_col <= n_in_col;
                r_window <= win_new;
                r_phase  <= n_in_col;
            end else begin
                if (restart_need) begin
                    r_in_row <= '0;
                    r_in_col <= '0;
                end
                if (rot) begin
                    r_phase <= n_phase;
                end else if ((r_len != ceff) && (r_phase == '0)) begin
                    r_len <= ceff;
                end
            end
        end
    end

    // line-store ring
    assign ring_ctl.shift = (in_acc && !res_last) || rot;
    assign ring_ctl.load  = in_acc && res_last;

    always_comb begin
        if (in_acc) begin
            wrap_bits.mid = v;
            wrap_bits.up  = cell_q[0].mid;
        end else begin
            wrap_bits = cell_q[0];
        end
    end

    for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
        t_cell_bits next_bits;
        if (k == MAX_COLS - 1) begin : g_end
            assign next_bits = '0;
        end else begin : g_mid
            assign next_bits = cell_q[k+1];
        end
        lag_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ring_ctl),
            .i_tail_idx (CW'(r_len - CW'(1))),
            .i_next     (next_bits),
            .i_wrap     (wrap_bits),
            .o_state    (cell_q[k])
        );
    end

    lag_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc && res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_data),
        .i_stall (i_stall)
    );

    assign o_next_cell     = out_data.next_cell;
    assign o_last_of_frame = out_data.last_of_frame;

    `LAG_ASSERT_NXT(a_last_restarts, i_clk, i_rst_n, in_acc && res_last, (r_in_row == '0) && (r_in_col == '0))
    `LAG_ASSERT_IMP(a_phase_in_ring, i_clk, i_rst_n, 1'b1, CW'(r_phase) < r_len)
    `LAG_ASSERT_IMP(a_row_bound, i_clk, i_rst_n, in_acc, r_in_row <= reff_p1)

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for life_automaton_generation_core (one B3/S23 generation per frame).
// Depends on lag_pkg and the core RTL; predicts each next-generation cell and checks the stream.

module tb;

    localparam int PERIOD_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES = 50;
    localparam int NUM_EXTREMES = 7;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic                          i_action = lag_pkg::ACT_CELL;
    logic                          i_cell_value = 1'b0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic                          o_next_cell;
    logic                          o_last_of_frame;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [lag_pkg::ADDR_W-1:0]    paddr = '0;
    logic [lag_pkg::DATA_W-1:0]    pwdata = '0;
    logic [lag_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    life_automaton_generation_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_cell_value   (i_cell_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_next_cell    (o_next_cell),
        .o_last_of_frame(o_last_of_frame),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // Generation predictor state
    logic [7:0]                        rows_reg = lag_pkg::RST_DIM;
    logic [7:0]                        cols_reg = lag_pkg::RST_DIM;
    logic [lag_pkg::DEF_MAX_COLS-1:0]  up_row = '0;
    logic [lag_pkg::DEF_MAX_COLS-1:0]  mid_row = '0;
    logic [8:0]                        nbhd = '0;
    int                                in_r = 0;
    int                                in_c = 0;
    lag_pkg::t_result                  next_gen_due[$];

    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int frames_sent = 0;
    int cycle_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int pressure_len = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;

    function automatic int eff_size(input logic [7:0] raw, input int top);
        if (raw == 8'd0) begin
            return 1;
        end
        if (int'(raw) > top) begin
            return top;
        end
        return int'(raw);
    endfunction

    function automatic logic [lag_pkg::ADDR_W-1:0] reg_addr(input logic idx);
        return {idx, 2'b00};
    endfunction

    function automatic void advance_generation(input logic act, input logic val);
        int nr;
        int nc;
        int cr;
        int cc;
        int nbrs;
        logic v;
        logic [2:0] col3;
        logic [8:0] prior;
        logic [8:0] w;
        logic hit;
        lag_pkg::t_result res;
        nr = eff_size(rows_reg, lag_pkg::DEF_MAX_ROWS);
        nc = eff_size(cols_reg, lag_pkg::DEF_MAX_COLS);
        hit = 1'b0;
        res = '0;
        if (in_r > nr + 1 || in_c >= nc) begin
            in_r = 0;
            in_c = 0;
        end
        v = (act == lag_pkg::ACT_CELL && in_r < nr) ? val : 1'b0;
        col3 = {v, mid_row[in_c], up_row[in_c]};
        up_row[in_c] = mid_row[in_c];
        mid_row[in_c] = v;
        prior = nbhd;
        nbhd = {col3, nbhd[8:3]};
        if (in_c == 0) begin
            w = {3'b000, prior[8:3]};
            cr = in_r - 2;
            cc = nc - 1;
            hit = (in_r >= 2) && (cr < nr);
        end else begin
            w = nbhd;
            cr = in_r - 1;
            cc = in_c - 1;
            hit = (in_r >= 1) && (cr < nr) && (cc < nc);
        end
        if (hit) begin
            if (cc == 0) w[2:0] = 3'b000;
            if (cc == nc - 1) w[8:6] = 3'b000;
            if (cr == 0) begin
                w[0] = 1'b0;
                w[3] = 1'b0;
                w[6] = 1'b0;
            end
            if (cr == nr - 1) begin
                w[2] = 1'b0;
                w[5] = 1'b0;
                w[8] = 1'b0;
            end
            nbrs = 0;
            for (int k = 0; k < 9; k++) begin
                if (k != 4) nbrs += int'(w[k]);
            end
            res.next_cell = w[4] ? (nbrs == 2 || nbrs == 3) : (nbrs == 3);
            res.last_of_frame = (cr == nr - 1) && (cc == nc - 1);
            next_gen_due.push_back(res);
        end
        if (in_c + 1 >= nc) begin
            in_c = 0;
            in_r++;
        end else begin
            in_c++;
        end
        if (hit && res.last_of_frame) begin
            in_r = 0;
            in_c = 0;
        end
    endfunction

    // Register copy, cell prediction and result checking, in that order each edge
    always @(posedge i_clk) begin : scoreboard
        lag_pkg::t_result due;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == reg_addr(lag_pkg::CFG_ROWS_IDX)) begin
                    rows_reg = pwdata[7:0];
                end else if (paddr == reg_addr(lag_pkg::CFG_COLS_IDX)) begin
                    cols_reg = pwdata[7:0];
                end
            end
            if (i_valid && !o_stall) begin
                advance_generation(i_action, i_cell_value);
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (next_gen_due.size() == 0) begin
                    $error("next_cell: expected no item, got %0d", o_next_cell);
                    fail_count++;
                end else begin
                    due = next_gen_due.pop_front();
                    if (o_next_cell !== due.next_cell) begin
                        $error("next_cell: expected %0d, got %0d", due.next_cell, o_next_cell);
                        fail_count++;
                    end
                    if (o_last_of_frame !== due.last_of_frame) begin
                        $error("last_of_frame: expected %0d, got %0d",
                               due.last_of_frame, o_last_of_frame);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!hold_used && pressure_len > 0) begin
            hold_left = pressure_len;
            hold_used = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > PERIOD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_cell_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid, let every result arrive, then let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        while (next_gen_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        logic [31:0] word;
        word = $urandom();
        word[7:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= reg_addr(idx);
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        reg_writes++;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== value) begin
            $error("register %0d: expected %0d, got %0d", idx, value, prdata[7:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] rows_raw, input logic [7:0] cols_raw);
        write_reg(lag_pkg::CFG_ROWS_IDX, rows_raw);
        write_reg(lag_pkg::CFG_COLS_IDX, cols_raw);
    endtask

    task automatic send_frame(input int nr, input int nc, input int density);
        for (int k = 0; k < nr * nc; k++) begin
            send_item(lag_pkg::ACT_CELL, $urandom_range(0, 99) < density);
        end
        for (int k = 0; k <= nc; k++) begin
            send_item(lag_pkg::ACT_FLUSH, $urandom_range(0, 1));
        end
        frames_sent++;
    endtask

    // Default 100x100 grid, then a size change mid-frame that keeps the position
    task automatic test_reset_config();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 2 * 100 + 5; k++) begin
            send_item(lag_pkg::ACT_CELL, $urandom_range(0, 1));
        end
        drain();
        configure(8'd4, 8'd8);
        for (int k = 0; k < 4 * 8 - (2 * 8 + 5); k++) begin
            send_item(lag_pkg::ACT_CELL, $urandom_range(0, 1));
        end
        for (int k = 0; k <= 8; k++) begin
            send_item(lag_pkg::ACT_FLUSH, 1'b0);
        end
        drain();
    endtask

    // Zero sizes act as one cell; early flush and late cell
    task automatic test_tiny_grid();
        configure(8'd0, 8'd0);
        send_item(lag_pkg::ACT_CELL, 1'b1);
        send_item(lag_pkg::ACT_FLUSH, 1'b1);
        send_item(lag_pkg::ACT_FLUSH, 1'b0);
        send_item(lag_pkg::ACT_FLUSH, 1'b1);
        send_item(lag_pkg::ACT_CELL, 1'b1);
        send_item(lag_pkg::ACT_CELL, 1'b1);
        drain();
    endtask

    // Vertical blinker: births, survival and deaths in one 3x3 frame
    task automatic test_blinker();
        logic [8:0] cells;
        cells = 9'b010_010_010;
        configure(8'd3, 8'd3);
        for (int k = 0; k < 9; k++) begin
            send_item(lag_pkg::ACT_CELL, cells[k]);
        end
        for (int k = 0; k < 4; k++) begin
            send_item(lag_pkg::ACT_FLUSH, 1'b1);
        end
        drain();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int quota,
                               input int phase_idx);
        logic [7:0] ext_rows [NUM_EXTREMES];
        logic [7:0] ext_cols [NUM_EXTREMES];
        logic [7:0] r_raw;
        logic [7:0] c_raw;
        int start;
        int pick;
        int nf;
        bit first;
        ext_rows = '{8'd255, 8'd1, 8'd129, 8'd0, 8'd128, 8'd2, 8'd1};
        ext_cols = '{8'd1, 8'd255, 8'd0, 8'd128, 8'd2, 8'd128, 8'd1};
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        first = 1'b1;
        while (items_sent - start < quota) begin
            if (first || $urandom_range(0, 99) < 4) begin
                pick = first ? phase_idx : $urandom_range(0, NUM_EXTREMES - 1);
                r_raw = ext_rows[pick];
                c_raw = ext_cols[pick];
            end else begin
                r_raw = $urandom_range(1, 7);
                c_raw = $urandom_range(1, 9);
            end
            first = 1'b0;
            configure(r_raw, c_raw);
            nf = $urandom_range(1, 4);
            for (int f = 0; f < nf && items_sent - start < quota; f++) begin
                send_frame(eff_size(r_raw, lag_pkg::DEF_MAX_ROWS),
                           eff_size(c_raw, lag_pkg::DEF_MAX_COLS),
                           $urandom_range(0, 4) * 20 + 10);
            end
            if ($urandom_range(0, 99) < 30) begin
                repeat ($urandom_range(1, 20)) begin
                    send_item($urandom_range(0, 1), $urandom_range(0, 1));
                end
            end
            drain();
        end
    endtask

    // Hold the output off long enough that the core must stall its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(8'd10, 8'd12);
        pressure_len = 300;
        send_frame(10, 12, 40);
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config();
        test_tiny_grid();
        test_blinker();
        test_random(0, 0, 320, 0);
        test_random(81, 0, 320, 1);
        test_random(0, 81, 320, 2);
        test_random(23, 23, 320, 3);
        test_backpressure();
        while (next_gen_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d items in %0d frames, checked %0d results, %0d register writes.",
                 items_sent, frames_sent, results_seen, reg_writes);
        $display("Covered free flow, sparse input, heavy output stall, mixed and a long hold-off.");
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
